// File: rtl/core/xrs_pkg.sv
package xrs_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CHUNK_W = 56;
  localparam int unsigned COEF_W  = 49;
  localparam int unsigned MOD_W   = 50;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned CARRY_W = 48;
  localparam int unsigned PHASE_W = 3;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [PHASE_W-1:0] LAST_PHASE = 3'd6;
  localparam logic [MOD_W-1:0]   MOD_RESET  = 50'd549824583172097;
  localparam logic [LEN_W-1:0]   LEN_RESET  = 11'd512;

  typedef enum logic {
    CFG_MODULUS = 1'b0,
    CFG_LENGTH  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic              last_coefficient;
  } res_t;

  // up to two results from one word, in chunk order
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

// File: rtl/core/xrs_in_if.sv
interface xrs_in_if;
  import xrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] rate_word;
  logic              start_vector;

  modport source (output valid, output rate_word, output start_vector, input ready);
  modport sink   (input valid, input rate_word, input start_vector, output ready);
endinterface

// File: rtl/core/xrs_out_if.sv
interface xrs_out_if;
  import xrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coefficient;
  logic              last_coefficient;

  modport source (output valid, output coefficient, output last_coefficient, input ready);
  modport sink   (input valid, input coefficient, input last_coefficient, output ready);
endinterface

// File: rtl/core/xrs_queue.sv
module xrs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  xrs_pkg::push_t push_i,
  output logic          room_o,
  xrs_out_if.source     out_o
);
  import xrs_pkg::*;

  res_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] level_q, level_d;
  logic              pop;

  assign out_o.valid            = (level_q != '0);
  assign out_o.coefficient      = mem_q[rd_ptr_q].coefficient;
  assign out_o.last_coefficient = mem_q[rd_ptr_q].last_coefficient;
  assign pop                    = out_o.valid & out_o.ready;

  // room for a two-result word, ignoring a pop in the same cycle
  assign room_o = (level_q <= QCNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop);
    level_d  = level_q + QCNT_W'(push_i.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + QPTR_W'(1)] <= push_i.second;
    end
  end

endmodule

// File: rtl/core/xof_rejection_sampler_mod_q.sv
// Channel   Dir  Payload                          Handshake
// in_i      in   rate_word[63:0], start_vector    valid/ready
// out_o     out  coefficient[48:0], last_coeff.   valid/ready
// cfg       in   cfg_idx_i, cfg_wdata_i[49:0]     cfg_we_i, no stall
//
// One rate word per cycle while in_i.ready is high. A word sits in the input
// register, its chunks are cut and tested there, and kept values land in a
// 4-entry result queue whose head drives out_o. Every seventh word yields two
// chunks; the output drains one per cycle while out_o.ready is high, so with a
// high keep rate the queue fill holds in_i.ready low now and then (up to 8
// results per 7 words). Reset clears phase, carry, count and queue.
module xof_rejection_sampler_mod_q #(
  parameter int unsigned VALUE_BITS = 49
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  xrs_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [xrs_pkg::MOD_W-1:0]   cfg_wdata_i,
  xrs_in_if.sink                      in_i,
  xrs_out_if.source                   out_o
);
  import xrs_pkg::*;

  localparam int unsigned CMP_W = (VALUE_BITS > MOD_W) ? VALUE_BITS : MOD_W;

  logic [MOD_W-1:0]   mod_q;
  logic [LEN_W-1:0]   len_q;

  logic               in_valid_q;
  logic [WORD_W-1:0]  word_q;
  logic               start_q;

  logic [CARRY_W-1:0] carry_q, carry_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [LEN_W-1:0]   count_q;

  logic               room;
  logic               advance;

  logic [PHASE_W-1:0]    p_eff;
  logic [CARRY_W-1:0]    carry_eff;
  logic [LEN_W-1:0]      cnt_eff, cnt1, cnt2;
  logic [5:0]            lsh, rsh;
  logic [CHUNK_W-1:0]    chunk0, chunk1;
  logic [VALUE_BITS-1:0] x0, x1;
  logic                  hit0, hit1, ok0, ok1;
  res_t                  res0, res1;
  push_t                 push;

  assign advance  = in_valid_q & room;
  assign in_i.ready = ~in_valid_q | advance;

  // chunk cutting and acceptance
  always_comb begin
    p_eff     = (start_q || (phase_q > LAST_PHASE)) ? '0 : phase_q;
    carry_eff = (start_q || (p_eff == '0)) ? '0 : carry_q;
    cnt_eff   = start_q ? '0 : count_q;

    lsh = {p_eff, 3'b000};
    rsh = 6'(7'd56 - {1'b0, p_eff, 3'b000});

    chunk0 = CHUNK_W'(word_q << lsh) | CHUNK_W'(carry_eff);
    chunk1 = CHUNK_W'(word_q >> 8);
    x0     = chunk0[VALUE_BITS-1:0];
    x1     = chunk1[VALUE_BITS-1:0];
    hit0   = (CMP_W'(x0) < CMP_W'(mod_q));
    hit1   = (CMP_W'(x1) < CMP_W'(mod_q));

    ok0  = (cnt_eff < len_q) && hit0;
    cnt1 = cnt_eff + LEN_W'(ok0);
    ok1  = (p_eff == LAST_PHASE) && (cnt1 < len_q) && hit1;
    cnt2 = cnt1 + LEN_W'(ok1);

    res0.coefficient      = COEF_W'(x0);
    res0.last_coefficient = (LEN_W'(cnt_eff + LEN_W'(1)) == len_q);
    res1.coefficient      = COEF_W'(x1);
    res1.last_coefficient = (LEN_W'(cnt1 + LEN_W'(1)) == len_q);

    carry_d = (p_eff == LAST_PHASE) ? '0 : CARRY_W'(word_q >> rsh);
    phase_d = (p_eff == LAST_PHASE) ? '0 : p_eff + PHASE_W'(1);

    push.count  = advance ? (2'(ok0) + 2'(ok1)) : 2'd0;
    push.first  = ok0 ? res0 : res1;
    push.second = res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_RESET;
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS: mod_q <= cfg_wdata_i;
        CFG_LENGTH:  len_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      carry_q    <= '0;
      phase_q    <= '0;
      count_q    <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        carry_q <= carry_d;
        phase_q <= phase_d;
        count_q <= cnt2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      word_q  <= in_i.rate_word;
      start_q <= in_i.start_vector;
    end
  end

  xrs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

  // two results only from the closing word of a group
  a_two_only_last_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count == 2'd2) |-> (p_eff == LAST_PHASE))
    else $error("two results outside last phase");

  // a word held back by a lack of queue room stays put
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(word_q) && $stable(start_q)))
    else $error("held word changed");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= LAST_PHASE)
    else $error("phase out of range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (ok0 || ok1)) |-> (cnt2 <= len_q))
    else $error("count passed vector length");

endmodule

// File: test/xof_rejection_sampler_mod_q_test.sv
module xof_rejection_sampler_mod_q_test;
  import xrs_pkg::*;

  localparam int unsigned VALUE_BITS = 49;
  localparam logic [CHUNK_W-1:0] VALUE_MASK = (56'd1 << VALUE_BITS) - 56'd1;
  localparam logic [MOD_W-1:0] MOD_TOP = 50'h2000000000000;   // 2^49, keeps every value
  localparam logic [MOD_W-1:0] MOD_HALF = 50'h1000000000000;  // 2^48
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [MOD_W-1:0]  val;
    logic [WORD_W-1:0] word;
    logic              start;
    bit                typed;
    int                n;
    res_t              r0;
    res_t              r1;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  cfg_idx_e cfg_idx;
  logic [MOD_W-1:0] cfg_wdata;
  bit calm = 1'b0;

  xrs_in_if  in_ch ();
  xrs_out_if out_ch ();

  xof_rejection_sampler_mod_q #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // sampler shadow state
  logic [MOD_W-1:0]   samp_modulus;
  logic [LEN_W-1:0]   samp_length;
  logic [CARRY_W-1:0] samp_carry;
  logic [PHASE_W-1:0] samp_phase;
  logic [LEN_W-1:0]   samp_count;

  res_t word_results[$];
  res_t pending_coefs[$];
  stim_row_t stim_rows[$];
  int mismatches = 0;
  int unsigned stall_cycles = 0;

  task automatic keep_chunk(input logic [CHUNK_W-1:0] chunk);
    logic [CHUNK_W-1:0] x;
    res_t r;
    x = chunk & VALUE_MASK;
    if (samp_count >= samp_length) return;
    if (x >= {6'b0, samp_modulus}) return;
    samp_count = samp_count + LEN_W'(1);
    r.coefficient = x[COEF_W-1:0];
    r.last_coefficient = (samp_count == samp_length);
    word_results.push_back(r);
  endtask

  task automatic cut_word(input logic [WORD_W-1:0] w, input logic s);
    logic [PHASE_W-1:0] p;
    logic [WORD_W-1:0] acc;
    word_results.delete();
    if (s) begin
      samp_count = '0;
      samp_phase = '0;
      samp_carry = '0;
    end
    p = (samp_phase > LAST_PHASE) ? '0 : samp_phase;
    if (p == 0) begin
      keep_chunk(w[55:0]);
      samp_carry = {40'b0, w[63:56]};
      samp_phase = 3'd1;
    end else if (p < LAST_PHASE) begin
      acc = {16'b0, samp_carry} | (w << (8 * p));
      keep_chunk(acc[55:0]);
      acc = w >> (56 - 8 * p);
      samp_carry = acc[CARRY_W-1:0];
      samp_phase = p + 3'd1;
    end else begin
      // last word of a group closes two chunks
      acc = {16'b0, samp_carry} | (w << 48);
      keep_chunk(acc[55:0]);
      keep_chunk(w[63:8]);
      samp_carry = '0;
      samp_phase = '0;
    end
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    int mode;
    mode = $urandom_range(0, 9);
    w = {$urandom, $urandom};
    if (mode == 0) w = '0;
    else if (mode == 1) w = '1;
    else if (mode >= 6) begin
      // zero bytes give small chunks for tight moduli
      for (int b = 0; b < 8; b++) begin
        if ($urandom_range(0, 1) == 1) w[8*b +: 8] = 8'h00;
      end
    end
    return w;
  endfunction

  function automatic void add_word(input logic [WORD_W-1:0] w, input logic s, input bit typed,
                                   input int n, input logic [COEF_W-1:0] c0, input logic l0,
                                   input logic [COEF_W-1:0] c1, input logic l1);
    stim_row_t row;
    row.kind = ROW_WORD;
    row.idx = CFG_MODULUS;
    row.val = '0;
    row.word = w;
    row.start = s;
    row.typed = typed;
    row.n = n;
    row.r0 = '{coefficient: c0, last_coefficient: l0};
    row.r1 = '{coefficient: c1, last_coefficient: l1};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input cfg_idx_e idx, input logic [MOD_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.val = val;
    row.word = '0;
    row.start = 1'b0;
    row.typed = 1'b0;
    row.n = 0;
    row.r0 = '0;
    row.r1 = '0;
    stim_rows.push_back(row);
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w, input logic s);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.rate_word <= w;
    in_ch.start_vector <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    cut_word(w, s);
  endtask

  // wait until the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [MOD_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_MODULUS) samp_modulus = val;
    else samp_length = val[LEN_W-1:0];
  endtask

  task automatic run_vectors(input int items);
    int left;
    logic s;
    logic [WORD_W-1:0] w;
    left = 0;
    repeat (items) begin
      s = 1'b0;
      if (left == 0) begin
        s = 1'b1;
        left = $urandom_range(1, 80);
      end else if ($urandom_range(0, 39) == 0) begin
        s = 1'b1;  // restart in mid vector
      end
      left--;
      w = rand_word();
      send_word(w, s);
      foreach (word_results[i]) pending_coefs.push_back(word_results[i]);
    end
  endtask

  always @(posedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_coefs.size() == 0) begin
        $error("coefficient: expected none, got %h", out_ch.coefficient);
        mismatches++;
      end else begin
        want = pending_coefs.pop_front();
        if (out_ch.coefficient !== want.coefficient) begin
          $error("coefficient: expected %h, got %h", want.coefficient, out_ch.coefficient);
          mismatches++;
        end
        if (out_ch.last_coefficient !== want.last_coefficient) begin
          $error("last_coefficient: expected %b, got %b", want.last_coefficient,
                 out_ch.last_coefficient);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("xof_rejection_sampler_mod_q_test: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [MOD_W-1:0] q;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MODULUS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rate_word = '0;
    in_ch.start_vector = 1'b0;
    samp_modulus = MOD_RESET;
    samp_length = LEN_RESET;
    samp_carry = '0;
    samp_phase = '0;
    samp_count = '0;

    // one full group of zero words: every chunk kept
    add_word('0, 1'b1, 1'b1, 1, '0, 1'b0, '0, 1'b0);
    repeat (5) add_word('0, 1'b0, 1'b1, 1, '0, 1'b0, '0, 1'b0);
    add_word('0, 1'b0, 1'b1, 2, '0, 1'b0, '0, 1'b0);
    // bounds around the reset modulus
    add_word('1, 1'b1, 1'b1, 0, '0, 1'b0, '0, 1'b0);
    add_word({14'b0, MOD_RESET} - 64'd1, 1'b1, 1'b1, 1, MOD_RESET[COEF_W-1:0] - 49'd1, 1'b0,
             '0, 1'b0);
    add_word({14'b0, MOD_RESET}, 1'b1, 1'b1, 0, '0, 1'b0, '0, 1'b0);
    add_word(64'h0123456789ABCDEF, 1'b0, 1'b0, 0, '0, 1'b0, '0, 1'b0);
    add_word(64'hFEDCBA9876543210, 1'b0, 1'b0, 0, '0, 1'b0, '0, 1'b0);
    // short vector, then words after it is complete, then a restart
    add_cfg(CFG_LENGTH, 50'd2);
    add_word('0, 1'b1, 1'b1, 1, '0, 1'b0, '0, 1'b0);
    add_word('0, 1'b0, 1'b1, 1, '0, 1'b1, '0, 1'b0);
    add_word('0, 1'b0, 1'b1, 0, '0, 1'b0, '0, 1'b0);
    add_word('0, 1'b1, 1'b1, 1, '0, 1'b0, '0, 1'b0);
    // smallest modulus keeps only zero
    add_cfg(CFG_MODULUS, 50'd1);
    add_cfg(CFG_LENGTH, 50'd1024);
    add_word(64'd1, 1'b1, 1'b1, 0, '0, 1'b0, '0, 1'b0);
    add_word(64'h00FFFFFFFFFFFF00, 1'b0, 1'b0, 0, '0, 1'b0, '0, 1'b0);
    // largest modulus keeps every value
    add_cfg(CFG_MODULUS, MOD_TOP);
    add_word('1, 1'b1, 1'b1, 1, '1, 1'b0, '0, 1'b0);
    add_word('1, 1'b0, 1'b0, 0, '0, 1'b0, '0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        set_reg(stim_rows[i].idx, stim_rows[i].val);
      end else begin
        send_word(stim_rows[i].word, stim_rows[i].start);
        if (stim_rows[i].typed) begin
          if (stim_rows[i].n >= 1) pending_coefs.push_back(stim_rows[i].r0);
          if (stim_rows[i].n == 2) pending_coefs.push_back(stim_rows[i].r1);
        end else begin
          foreach (word_results[j]) pending_coefs.push_back(word_results[j]);
        end
      end
    end

    set_reg(CFG_MODULUS, MOD_TOP);
    set_reg(CFG_LENGTH, 50'd1);
    run_vectors(130);

    set_reg(CFG_MODULUS, 50'd1);
    set_reg(CFG_LENGTH, 50'd1024);
    run_vectors(120);

    // high keep rate with no idling on either side fills the result queue
    set_reg(CFG_MODULUS, MOD_RESET);
    calm = 1'b1;
    run_vectors(140);
    calm = 1'b0;

    repeat (4) begin
      q = MOD_W'({$urandom, $urandom});
      q[MOD_W-1] = 1'b0;
      if (q == 0) q = 50'd1;
      set_reg(CFG_MODULUS, q);
      set_reg(CFG_LENGTH, 50'($urandom_range(1, 40)));
      run_vectors(130);
    end

    set_reg(CFG_MODULUS, 50'($urandom_range(1, 1 << 24)));
    set_reg(CFG_LENGTH, 50'($urandom_range(1, 8)));
    run_vectors(120);

    set_reg(CFG_MODULUS, MOD_HALF);
    set_reg(CFG_LENGTH, 50'd17);
    run_vectors(120);

    settle();
    if (mismatches == 0) begin
      $display("xof_rejection_sampler_mod_q_test: clean");
    end else begin
      $display("xof_rejection_sampler_mod_q_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/xrs_pkg.sv
rtl/core/xrs_in_if.sv
rtl/core/xrs_out_if.sv
rtl/core/xrs_queue.sv
rtl/core/xof_rejection_sampler_mod_q.sv
test/xof_rejection_sampler_mod_q_test.sv
